/* design/rrs_pkg.sv */
// Shared types and constants for the run queue scheduler.
package rrs_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_ID_BITS     = 8;
	localparam int ID_FIELD_W      = 8;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 5;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_ENTER  = 2'd0,
		OP_LEAVE  = 2'd1,
		OP_SELECT = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY   = 1'b0,
		CFG_CAPACITY = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [ID_FIELD_W-1:0] thread_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [ID_FIELD_W-1:0] selected_id;
	} out_item_t;

	// Datapath operations, one per cycle.
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_ENTER,
		DP_SCAN_START,
		DP_SCAN_NEXT,
		DP_SHIFT_RD,
		DP_SHIFT_WR,
		DP_LEAVE_OK,
		DP_NOT_FOUND,
		DP_RD_HEAD,
		DP_ROT_WR,
		DP_SEL_OK,
		DP_SEL_EMPTY,
		DP_NOP_OK,
		DP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opcode;
		logic    count_zero;
		logic    match;
		logic    k_last;
		logic    rot_needed;
		logic    out_free;
	} dp_stat_t;

endpackage

/* design/run_queue_fifo_rr_scheduler.sv */
// Round-robin / FIFO run queue scheduler: top level.
// Enter and no-op record their result directly; select reads the head entry, first
// moving it to the tail when a rotation is due. Leave scans the queue memory entry
// by entry, then shifts each entry behind the removed one down by one place.
// One item is worked at a time; a finished result waits in the result register
// until the output register frees up. Reset clears the entry count, current mark,
// policy (FIFO) and capacity (16); the queue memory is not cleared.
module run_queue_fifo_rr_scheduler import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	rrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rrs_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* design/rrs_dpath.sv */
// Datapath: queue memory as a ring, pointers, config registers and result register.
module rrs_dpath import rrs_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int ID_BITS     = DEF_ID_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ID_W  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [ID_W-1:0]       mem [QUEUE_DEPTH];
	logic [ID_W-1:0]       rdata_q;
	logic [ID_W-1:0]       id_q;
	logic [1:0]            op_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      k_q;
	logic                  cur_q;
	logic                  policy_q;
	logic [CAP_W-1:0]      capacity_q;
	status_t               res_status_q;
	logic [ID_FIELD_W-1:0] res_id_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [CNT_W-1:0] k_next;
	logic             full;
	logic             rd_en;
	logic [PTR_W-1:0] raddr;
	logic             we;
	logic [PTR_W-1:0] waddr;
	logic [ID_W-1:0]  wdata;

	// Ring address: base plus offset, folded once into the queue depth.
	function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign k_next = k_q + CNT_W'(1);
	assign full   = (count_q >= CNT_W'(QUEUE_DEPTH)) ||
		(CMP_W'(count_q) >= CMP_W'(capacity_q));

	always_comb begin
		rd_en = 1'b0;
		raddr = head_q;
		we    = 1'b0;
		waddr = ring_addr(head_q, count_q);
		wdata = rdata_q;
		case (cmd.op)
			DP_SCAN_START: begin
				rd_en = 1'b1;
				raddr = ring_addr(head_q, k_q);
			end
			DP_SCAN_NEXT, DP_SHIFT_RD: begin
				rd_en = 1'b1;
				raddr = ring_addr(head_q, k_next);
			end
			DP_RD_HEAD: begin
				rd_en = 1'b1;
			end
			DP_ENTER: begin
				we    = !full;
				wdata = id_q;
			end
			DP_SHIFT_WR: begin
				we    = 1'b1;
				waddr = ring_addr(head_q, k_q);
			end
			DP_ROT_WR: begin
				we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= in_data.opcode;
			id_q <= in_data.thread_id[ID_W-1:0];
		end
		case (cmd.op)
			DP_ENTER: begin
				res_status_q <= full ? STAT_FULL : STAT_OK;
				res_id_q     <= '0;
			end
			DP_LEAVE_OK, DP_NOP_OK: begin
				res_status_q <= STAT_OK;
				res_id_q     <= '0;
			end
			DP_NOT_FOUND: begin
				res_status_q <= STAT_NOT_FOUND;
				res_id_q     <= '0;
			end
			DP_SEL_EMPTY: begin
				res_status_q <= STAT_EMPTY;
				res_id_q     <= '0;
			end
			DP_SEL_OK: begin
				res_status_q <= STAT_OK;
				res_id_q     <= ID_FIELD_W'(rdata_q);
			end
			default: begin
			end
		endcase
		if (cmd.op == DP_PUBLISH) begin
			out_q.status      <= res_status_q;
			out_q.selected_id <= res_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			k_q         <= '0;
			cur_q       <= 1'b0;
			policy_q    <= 1'b0;
			capacity_q  <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_POLICY:   policy_q   <= cfg_data[0];
					CFG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				k_q <= '0;
			end
			case (cmd.op)
				DP_ENTER: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				DP_SCAN_NEXT, DP_SHIFT_WR: begin
					k_q <= k_next;
				end
				DP_LEAVE_OK: begin
					count_q <= count_q - CNT_W'(1);
					cur_q   <= 1'b0;
				end
				DP_ROT_WR: begin
					// head entry now sits at the tail; advance the head
					head_q <= ring_addr(head_q, CNT_W'(1));
				end
				DP_SEL_OK: begin
					cur_q <= cur_q | policy_q;
				end
				DP_SEL_EMPTY: begin
					cur_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (cmd.op == DP_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.opcode     = opcode_t'(op_q);
	assign stat.count_zero = (count_q == '0);
	assign stat.match      = (rdata_q == id_q);
	assign stat.k_last     = (k_next >= count_q);
	assign stat.rot_needed = policy_q && cur_q && (count_q != '0);
	assign stat.out_free   = !out_valid_q || out_ready;

endmodule

/* design/rrs_ctrl.sv */
// Controller: sequences the datapath through enter, leave scan and shift, select with rotation, and no-op.
module rrs_ctrl import rrs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_LV_CMP,
		S_SH_RD,
		S_SH_WR,
		S_ROT_WR,
		S_SEL_RD,
		S_SEL_OUT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.accept = 1'b0;
		cmd.op     = DP_IDLE;
		case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.opcode)
					OP_ENTER: begin
						cmd.op  = DP_ENTER;
						state_d = S_DONE;
					end
					OP_LEAVE: begin
						if (stat.count_zero) begin
							cmd.op  = DP_NOT_FOUND;
							state_d = S_DONE;
						end else begin
							cmd.op  = DP_SCAN_START;
							state_d = S_LV_CMP;
						end
					end
					OP_SELECT: begin
						if (stat.rot_needed) begin
							cmd.op  = DP_RD_HEAD;
							state_d = S_ROT_WR;
						end else if (stat.count_zero) begin
							cmd.op  = DP_SEL_EMPTY;
							state_d = S_DONE;
						end else begin
							cmd.op  = DP_RD_HEAD;
							state_d = S_SEL_OUT;
						end
					end
					default: begin
						cmd.op  = DP_NOP_OK;
						state_d = S_DONE;
					end
				endcase
			end
			S_LV_CMP: begin
				// compare the entry read last cycle; fetch the next one if it does not match
				if (stat.match) begin
					state_d = S_SH_RD;
				end else if (stat.k_last) begin
					cmd.op  = DP_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					cmd.op = DP_SCAN_NEXT;
				end
			end
			S_SH_RD: begin
				if (stat.k_last) begin
					cmd.op  = DP_LEAVE_OK;
					state_d = S_DONE;
				end else begin
					cmd.op  = DP_SHIFT_RD;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd.op  = DP_SHIFT_WR;
				state_d = S_SH_RD;
			end
			S_ROT_WR: begin
				cmd.op  = DP_ROT_WR;
				state_d = S_SEL_RD;
			end
			S_SEL_RD: begin
				cmd.op  = DP_RD_HEAD;
				state_d = S_SEL_OUT;
			end
			S_SEL_OUT: begin
				cmd.op  = DP_SEL_OK;
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (stat.out_free) begin
					cmd.op  = DP_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
